// ----- rtl/tarpt_pkg.sv -----
// Shared types and constants of the three-axis rate controller.
package tarpt_pkg;

  // Field and arithmetic widths.
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 16;
  localparam int ACC_W     = 32;
  localparam int DT_W      = 16;
  localparam int FLAG_W    = 7;
  localparam int REG_COUNT = 8;
  localparam int REG_W     = 3 * COEF_W;
  localparam int IDX_W     = $clog2(REG_COUNT);
  localparam int OPND_W    = 33;
  localparam int PROD_W    = 64;
  localparam int OMEGA_W   = 26;
  localparam int CROSS_W   = 40;
  localparam int REM_W     = 47;
  localparam int QUO_W     = 17;
  localparam int CTR_W     = 5;
  localparam int ESQ_W     = 30;
  localparam int RECIP_W   = 32;
  localparam int RPROD_W   = ESQ_W + RECIP_W;

  // Steps of the error-weight divider: reciprocal product, estimate,
  // back-multiplication and the final remainder check.
  localparam int DIV_STEPS = 4;

  // 400 degrees per second in Q11.12 radians, its square, twice and half the
  // square, and the reciprocal of the square scaled by two to the 61.
  localparam logic signed [SAMPLE_W:0] RAD400    = 25'sd28595;
  localparam logic [REM_W-1:0]         RAD_SQ    = 47'd817674025;
  localparam logic [REM_W-1:0]         RAD_SQ2   = 47'd1635348050;
  localparam logic [REM_W-1:0]         RAD_SQ_H  = 47'd408837012;
  localparam logic [RECIP_W-1:0]       RECIP_Q61 = 32'd2820002762;
  localparam logic [QUO_W-1:0]         UNITY_Q16 = 17'd65536;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_PROP      = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG     = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV     = 3'd2;
  localparam logic [IDX_W-1:0] REG_FEEDFWD   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIMIT     = 3'd4;
  localparam logic [IDX_W-1:0] REG_INERTIA_A = 3'd5;
  localparam logic [IDX_W-1:0] REG_INERTIA_B = 3'd6;
  localparam logic [IDX_W-1:0] REG_INERTIA_C = 3'd7;

  // Command codes of an input beat.
  localparam logic CMD_RUN   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Bit of the status flags that marks the vehicle as landed.
  localparam int FLAG_LANDED = 6;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] rate_x;
    logic signed [SAMPLE_W-1:0] rate_y;
    logic signed [SAMPLE_W-1:0] rate_z;
    logic signed [SAMPLE_W-1:0] target_x;
    logic signed [SAMPLE_W-1:0] target_y;
    logic signed [SAMPLE_W-1:0] target_z;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic [DT_W-1:0]            step_time;
    logic [FLAG_W-1:0]          status_flags;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] torque_x;
    logic signed [ACC_W-1:0] torque_y;
    logic signed [ACC_W-1:0] torque_z;
    logic signed [ACC_W-1:0] accel_sp_x;
    logic signed [ACC_W-1:0] accel_sp_y;
    logic signed [ACC_W-1:0] accel_sp_z;
    logic signed [ACC_W-1:0] integral_x;
    logic signed [ACC_W-1:0] integral_y;
    logic signed [ACC_W-1:0] integral_z;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_ACCEL, S_OMEGA, S_WDRAIN, S_CROSS, S_TORQUE, S_TDRAIN,
    S_ISQ, S_ISQ_W, S_DIV_INIT, S_DIV, S_IP1, S_IP1_W, S_IP2, S_IP2_W,
    S_IP3, S_IP3_W, S_IUPD, S_FINISH
  } state_t;

  // Which product the shared multiplier forms.
  typedef enum logic [2:0] {
    PH_ACCEL, PH_OMEGA, PH_CROSS, PH_TORQUE, PH_ESQ, PH_IP1, PH_IP2, PH_IP3
  } phase_t;

  typedef struct packed {
    logic       issue;
    phase_t     phase;
    logic [1:0] axis;
    logic [1:0] term;
    logic       first;
    logic       last;
  } mul_cmd_t;

  typedef struct packed {
    mul_cmd_t mul;
    logic     capture;
    logic     clear;
    logic     div_init;
    logic     div_step;
    logic     integ_wr;
    logic     load_out;
  } dp_ctl_t;

  typedef struct packed {
    logic is_clear;
    logic landed;
  } dp_stat_t;

endpackage

// ----- rtl/tarpt_ctrl.sv -----
// Sequencer: walks one update through the shared multiplier, divider and
// write-back steps, and owns both handshakes.
module tarpt_ctrl import tarpt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_ctl_t  ctl,
  input  dp_stat_t stat
);

  state_t            state_r, state_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [CTR_W-1:0]  ctr_r, ctr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt         = state_r;
    axis_nxt          = axis_r;
    ctr_nxt           = ctr_r;
    ctl               = '0;
    ctl.mul.phase     = PH_ACCEL;
    ctl.mul.axis      = axis_r;
    ctl.mul.term      = ctr_r[1:0];
    ctl.mul.first     = (ctr_r == '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        axis_nxt = '0;
        ctr_nxt  = '0;
        if (stat.is_clear) begin
          ctl.clear = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_ACCEL;
        end
      end
      S_ACCEL, S_OMEGA, S_CROSS, S_TORQUE: begin
        ctl.mul.issue = 1'b1;
        priority case (state_r)
          S_ACCEL:  begin
            ctl.mul.phase = PH_ACCEL;
            ctl.mul.last  = (ctr_r == CTR_W'(1));
          end
          S_OMEGA:  begin
            ctl.mul.phase = PH_OMEGA;
            ctl.mul.last  = (ctr_r == CTR_W'(2));
          end
          S_CROSS:  begin
            ctl.mul.phase = PH_CROSS;
            ctl.mul.last  = (ctr_r == CTR_W'(1));
          end
          default: begin
            ctl.mul.phase = PH_TORQUE;
            ctl.mul.last  = (ctr_r == CTR_W'(3));
          end
        endcase
        if (ctl.mul.last) begin
          ctr_nxt = '0;
          if (axis_r == 2'd2) begin
            axis_nxt = '0;
            priority case (state_r)
              S_ACCEL: state_nxt = S_OMEGA;
              S_OMEGA: state_nxt = S_WDRAIN;
              S_CROSS: state_nxt = S_TORQUE;
              default: state_nxt = S_TDRAIN;
            endcase
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          ctr_nxt = ctr_r + CTR_W'(1);
        end
      end
      S_WDRAIN, S_TDRAIN: begin
        // Let the last sum of the phase reach its register.
        if (ctr_r == CTR_W'(1)) begin
          ctr_nxt = '0;
          if (state_r == S_WDRAIN) begin
            state_nxt = S_CROSS;
          end else if (stat.landed) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_ISQ;
          end
        end else begin
          ctr_nxt = ctr_r + CTR_W'(1);
        end
      end
      S_ISQ: begin
        ctl.mul.issue = 1'b1;
        ctl.mul.phase = PH_ESQ;
        state_nxt     = S_ISQ_W;
      end
      S_ISQ_W: state_nxt = S_DIV_INIT;
      S_DIV_INIT: begin
        ctl.div_init = 1'b1;
        ctr_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (ctr_r == CTR_W'(DIV_STEPS - 1)) begin
          ctr_nxt   = '0;
          state_nxt = S_IP1;
        end else begin
          ctr_nxt = ctr_r + CTR_W'(1);
        end
      end
      S_IP1: begin
        ctl.mul.issue = 1'b1;
        ctl.mul.phase = PH_IP1;
        state_nxt     = S_IP1_W;
      end
      S_IP1_W: state_nxt = S_IP2;
      S_IP2: begin
        ctl.mul.issue = 1'b1;
        ctl.mul.phase = PH_IP2;
        state_nxt     = S_IP2_W;
      end
      S_IP2_W: state_nxt = S_IP3;
      S_IP3: begin
        ctl.mul.issue = 1'b1;
        ctl.mul.phase = PH_IP3;
        state_nxt     = S_IP3_W;
      end
      S_IP3_W: state_nxt = S_IUPD;
      S_IUPD: begin
        ctl.integ_wr = 1'b1;
        if (axis_r == 2'd2) begin
          axis_nxt  = '0;
          state_nxt = S_FINISH;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_ISQ;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result beat is held until the far side takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/tarpt_datapath.sv -----
// Datapath: configuration registers, the captured beat, one shared signed
// multiplier with an accumulator behind it, a reciprocal-multiplication
// divider for the error weight, and the controller state.
module tarpt_datapath import tarpt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_wdata,
  input  in_item_t         in_data,
  input  dp_ctl_t          ctl,
  output dp_stat_t         stat,
  output out_item_t        out_data
);

  localparam int FRAC_BITS_L = 12;

  logic [REG_W-1:0]          cfg_r [REG_COUNT];
  in_item_t                  in_r;
  out_item_t                 out_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  acc_r, acc_nxt;
  mul_cmd_t                  cmd_d1_r, cmd_d2_r;
  logic signed [OMEGA_W-1:0] omega_r  [3];
  logic signed [CROSS_W-1:0] cross_r  [3];
  logic signed [ACC_W-1:0]   accel_r  [3];
  logic signed [ACC_W-1:0]   torque_r [3];
  logic signed [ACC_W-1:0]   integ_r  [3];
  logic [ESQ_W-1:0]          esq_r;
  logic [RPROD_W-1:0]        rprod_r;
  logic [QUO_W-1:0]          q0_r;
  logic [REM_W-1:0]          qr_r;
  logic [QUO_W-1:0]          quo_r;

  logic signed [SAMPLE_W-1:0] rate_v [3];
  logic signed [SAMPLE_W-1:0] tgt_v  [3];
  logic signed [SAMPLE_W-1:0] acc_in [3];
  logic signed [SAMPLE_W:0]   err_v  [3];
  logic signed [SAMPLE_W:0]   ev_v   [3];
  logic                       in_rng [3];
  logic signed [OPND_W-1:0]   opa, opb;
  logic signed [2*OPND_W-1:0] prod_full;
  logic [1:0]                 ax1, ax2;
  logic [QUO_W-1:0]           weight;
  logic [REM_W-1:0]           num_v, rem_v;
  logic [QUO_W-1:0]           q_inc;
  logic signed [PROD_W-1:0]   omega_rnd, cross_rnd;
  logic signed [PROD_W-1:0]   integ_sum, integ_clamped, lim_s;

  function automatic logic signed [COEF_W-1:0] coef(input logic [REG_W-1:0] v,
                                                      input logic [1:0] i);
    logic signed [COEF_W-1:0] c;
    unique case (i)
      2'd0:    c = v[COEF_W-1:0];
      2'd1:    c = v[2*COEF_W-1:COEF_W];
      default: c = v[3*COEF_W-1:2*COEF_W];
    endcase
    return c;
  endfunction

  function automatic logic [REG_W-1:0] inertia_row(input logic [1:0] i);
    logic [REG_W-1:0] v;
    unique case (i)
      2'd0:    v = cfg_r[REG_INERTIA_A];
      2'd1:    v = cfg_r[REG_INERTIA_B];
      default: v = cfg_r[REG_INERTIA_C];
    endcase
    return v;
  endfunction

  // Round to nearest with ties upwards, then shift right arithmetically.
  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] v,
                                                   input int s);
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] sum;
    half = 64'sd1 <<< (s - 1);
    sum  = v + half;
    return sum >>> s;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] axis_next(input logic [1:0] a);
    logic [1:0] n;
    unique case (a)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // Capture of the accepted beat.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      in_r <= in_data;
    end
  end

  assign stat.is_clear = (in_r.cmd == CMD_CLEAR);
  assign stat.landed   = in_r.status_flags[FLAG_LANDED];

  // Per-axis vectors, the error and the error clipped by the saturation flags.
  always_comb begin
    rate_v[0] = in_r.rate_x;   rate_v[1] = in_r.rate_y;   rate_v[2] = in_r.rate_z;
    tgt_v[0]  = in_r.target_x; tgt_v[1]  = in_r.target_y; tgt_v[2]  = in_r.target_z;
    acc_in[0] = in_r.accel_x;  acc_in[1] = in_r.accel_y;  acc_in[2] = in_r.accel_z;
    for (int i = 0; i < 3; i++) begin
      err_v[i] = (SAMPLE_W + 1)'(tgt_v[i]) - (SAMPLE_W + 1)'(rate_v[i]);
      ev_v[i]  = err_v[i];
      if (in_r.status_flags[i] && (err_v[i] > 0)) begin
        ev_v[i] = '0;
      end
      if (in_r.status_flags[3 + i] && (err_v[i] < 0)) begin
        ev_v[i] = '0;
      end
      in_rng[i] = (ev_v[i] < RAD400) && (ev_v[i] > -RAD400);
    end
  end

  assign ax1    = axis_next(ctl.mul.axis);
  assign ax2    = axis_next(ax1);
  assign weight = UNITY_Q16 - quo_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctl.mul.phase)
      PH_ACCEL: begin
        if (ctl.mul.term == 2'd0) begin
          opa = OPND_W'(coef(cfg_r[REG_PROP], ctl.mul.axis));
          opb = OPND_W'(err_v[ctl.mul.axis]);
        end else begin
          opa = OPND_W'(coef(cfg_r[REG_DERIV], ctl.mul.axis));
          opb = OPND_W'(acc_in[ctl.mul.axis]);
        end
      end
      PH_OMEGA: begin
        opa = OPND_W'(coef(inertia_row(ctl.mul.axis), ctl.mul.term));
        opb = OPND_W'(rate_v[ctl.mul.term]);
      end
      PH_CROSS: begin
        if (ctl.mul.term == 2'd0) begin
          opa = OPND_W'(rate_v[ax1]);
          opb = OPND_W'(omega_r[ax2]);
        end else begin
          opa = OPND_W'(rate_v[ax2]);
          opb = OPND_W'(omega_r[ax1]);
        end
      end
      PH_TORQUE: begin
        if (ctl.mul.term == 2'd3) begin
          opa = OPND_W'(coef(cfg_r[REG_FEEDFWD], ctl.mul.axis));
          opb = OPND_W'(tgt_v[ctl.mul.axis]);
        end else begin
          opa = OPND_W'(coef(inertia_row(ctl.mul.axis), ctl.mul.term));
          opb = OPND_W'(accel_r[ctl.mul.term]);
        end
      end
      PH_ESQ: begin
        opa = OPND_W'(ev_v[ctl.mul.axis]);
        opb = OPND_W'(ev_v[ctl.mul.axis]);
      end
      PH_IP1: begin
        opa = OPND_W'(coef(cfg_r[REG_INTEG], ctl.mul.axis));
        opb = OPND_W'(ev_v[ctl.mul.axis]);
      end
      PH_IP2: begin
        opa = acc_r[OPND_W-1:0];
        opb = OPND_W'(weight);
      end
      default: begin
        opa = acc_r[OPND_W-1:0];
        opb = OPND_W'(in_r.step_time);
      end
    endcase
  end

  assign prod_full = opa * opb;

  // Product register and the command that travels with it.
  always_ff @(posedge clk) begin
    prod_r <= prod_full[PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_d1_r <= '0;
      cmd_d2_r <= '0;
    end else begin
      cmd_d1_r <= ctl.mul;
      cmd_d2_r <= cmd_d1_r;
    end
  end

  // Accumulator stage.
  always_comb begin
    acc_nxt = acc_r;
    if (cmd_d1_r.issue) begin
      unique case (cmd_d1_r.phase)
        PH_ACCEL, PH_CROSS: acc_nxt = cmd_d1_r.first ? prod_r : acc_r - prod_r;
        PH_OMEGA:           acc_nxt = cmd_d1_r.first ? prod_r : acc_r + prod_r;
        PH_TORQUE: begin
          if (cmd_d1_r.term == 2'd3) begin
            acc_nxt = rnd(acc_r, 16) + rnd(prod_r, FRAC_BITS_L)
                    + PROD_W'(integ_r[cmd_d1_r.axis]) + PROD_W'(cross_r[cmd_d1_r.axis]);
          end else begin
            acc_nxt = cmd_d1_r.first ? prod_r : acc_r + prod_r;
          end
        end
        PH_ESQ, PH_IP1: acc_nxt = prod_r;
        PH_IP2:         acc_nxt = rnd(prod_r, 16);
        default:        acc_nxt = rnd(prod_r, 32);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Write-back of finished sums.
  assign omega_rnd = rnd(acc_r, 16);
  assign cross_rnd = rnd(acc_r, FRAC_BITS_L);

  always_ff @(posedge clk) begin
    if (cmd_d2_r.issue && cmd_d2_r.last) begin
      unique case (cmd_d2_r.phase)
        PH_OMEGA: omega_r[cmd_d2_r.axis] <= omega_rnd[OMEGA_W-1:0];
        PH_CROSS: cross_r[cmd_d2_r.axis] <= cross_rnd[CROSS_W-1:0];
        default: ;
      endcase
    end
  end

  // Integrator step and clamp to the configured magnitude.
  always_comb begin
    lim_s     = PROD_W'(coef(cfg_r[REG_LIMIT], ctl.mul.axis)) & 64'sh0000_0000_0000_ffff;
    integ_sum = PROD_W'(integ_r[ctl.mul.axis]) + (in_rng[ctl.mul.axis] ? acc_r : '0);
    if (integ_sum > lim_s) begin
      integ_clamped = lim_s;
    end else if (integ_sum < -lim_s) begin
      integ_clamped = -lim_s;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  // Controller state: acceleration setpoint, torque and integrator.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < 3; i++) begin
        accel_r[i]  <= '0;
        torque_r[i] <= '0;
        integ_r[i]  <= '0;
      end
    end else begin
      if (cmd_d2_r.issue && cmd_d2_r.last && (cmd_d2_r.phase == PH_ACCEL)) begin
        accel_r[cmd_d2_r.axis] <= sat32(rnd(acc_r, FRAC_BITS_L));
      end
      if (cmd_d2_r.issue && cmd_d2_r.last && (cmd_d2_r.phase == PH_TORQUE)) begin
        torque_r[cmd_d2_r.axis] <= sat32(acc_r);
      end
      if (ctl.integ_wr) begin
        integ_r[ctl.mul.axis] <= integ_clamped[ACC_W-1:0];
      end
    end
  end

  // Division by the squared error range: an estimate from the scaled
  // reciprocal falls short by at most two, so the remainder left after
  // multiplying back decides the last one or two units.
  assign num_v = REM_W'({esq_r, 16'b0}) + RAD_SQ_H;
  assign rem_v = num_v - qr_r;

  always_comb begin
    priority if (rem_v >= RAD_SQ2) begin
      q_inc = QUO_W'(2);
    end else if (rem_v >= RAD_SQ) begin
      q_inc = QUO_W'(1);
    end else begin
      q_inc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      esq_r <= acc_r[ESQ_W-1:0];
    end else if (ctl.div_step) begin
      rprod_r <= esq_r * RECIP_Q61;
      q0_r    <= rprod_r[RPROD_W-1:RPROD_W-QUO_W];
      qr_r    <= q0_r * RAD_SQ;
      quo_r   <= q0_r + q_inc;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_r.torque_x   <= torque_r[0];
      out_r.torque_y   <= torque_r[1];
      out_r.torque_z   <= torque_r[2];
      out_r.accel_sp_x <= accel_r[0];
      out_r.accel_sp_y <= accel_r[1];
      out_r.accel_sp_z <= accel_r[2];
      out_r.integral_x <= integ_r[0];
      out_r.integral_y <= integ_r[1];
      out_r.integral_z <= integ_r[2];
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/three_axis_rate_pid_torque_unit.sv -----
// Three-axis rate PID with feedforward, gyroscopic term and integrator
// anti-windup. Every product of an update goes through one shared 33 x 33
// signed multiplier with an accumulator behind it, and each axis of the
// integrator also passes through a reciprocal-multiplication divider for
// the error weight; a landed beat skips the integrator and a clear command
// skips every product. Input is taken only when the block is idle, so a
// new update beat is not accepted until the previous one is through; a
// finished result sits in an output register so a new beat may be taken
// while the previous result still waits.
module three_axis_rate_pid_torque_unit import tarpt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_wdata
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  tarpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

  tarpt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/tarpt_checker.sv -----
// Port-level checks of the rate controller.
module tarpt_checker import tarpt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_stall,
  input out_item_t        out_data,
  input logic             cfg_we,
  input logic [IDX_W-1:0] cfg_index,
  input logic [REG_W-1:0] cfg_wdata
);

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One beat at a time: the input side closes right after an acceptance.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a beat is in progress");

  // A clear command accepted while no result waits gives an all-zero result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == CMD_CLEAR) && !out_valid
      |-> ##3 out_valid && (out_data == '0))
    else $error("clear command did not give a zero result");

  // A new result only appears while a beat is in progress.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a beat in progress");

endmodule

bind three_axis_rate_pid_torque_unit tarpt_checker u_tarpt_checker (.*);

// ----- dv/three_axis_rate_pid_torque_unit_chk.sv -----
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the rate controller.
// It mirrors the registers and the controller state, works out the beat
// that each accepted update should yield, and compares it with what leaves.
module three_axis_rate_pid_torque_unit_chk import tarpt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count
);

  localparam longint RAD_Q12 = 28595;

  logic [REG_W-1:0] reg_mirror [REG_COUNT];
  longint           integ_st [3];
  longint           torque_st [3];
  longint           accsp_st [3];
  out_item_t        torque_queue [$];

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint gain_of(int idx, int axis);
    logic signed [COEF_W-1:0] g;
    g = reg_mirror[idx][COEF_W*axis +: COEF_W];
    return longint'(g);
  endfunction

  // Advances the mirrored state by one beat and returns the result beat.
  function automatic out_item_t predict_torque(in_item_t b);
    longint    r [3];
    longint    t [3];
    longint    a [3];
    longint    e [3];
    longint    w [3];
    longint    c [3];
    longint    s, ev, lim, nv, q, f, p, r2;
    out_item_t o;
    if (b.cmd == CMD_CLEAR) begin
      for (int i = 0; i < 3; i++) begin
        integ_st[i] = 0;
        torque_st[i] = 0;
        accsp_st[i] = 0;
      end
    end else begin
      r[0] = b.rate_x;   r[1] = b.rate_y;   r[2] = b.rate_z;
      t[0] = b.target_x; t[1] = b.target_y; t[2] = b.target_z;
      a[0] = b.accel_x;  a[1] = b.accel_y;  a[2] = b.accel_z;
      for (int i = 0; i < 3; i++) e[i] = t[i] - r[i];
      for (int i = 0; i < 3; i++) begin
        accsp_st[i] = sat_word(round_shift(gain_of(REG_PROP, i) * e[i]
                                           - gain_of(REG_DERIV, i) * a[i], 12));
      end
      // Angular momentum J*rate, then the gyroscopic cross product.
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) s += gain_of(REG_INERTIA_A + i, j) * r[j];
        w[i] = round_shift(s, 16);
      end
      c[0] = round_shift(r[1] * w[2] - r[2] * w[1], 12);
      c[1] = round_shift(r[2] * w[0] - r[0] * w[2], 12);
      c[2] = round_shift(r[0] * w[1] - r[1] * w[0], 12);
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) s += gain_of(REG_INERTIA_A + i, j) * accsp_st[j];
        s = round_shift(s, 16);
        s += integ_st[i] + round_shift(gain_of(REG_FEEDFWD, i) * t[i], 12) + c[i];
        torque_st[i] = sat_word(s);
      end
      // Integrator with saturation clipping, error weighting and clamping.
      if (!b.status_flags[FLAG_LANDED]) begin
        for (int i = 0; i < 3; i++) begin
          ev = e[i];
          lim = longint'(reg_mirror[REG_LIMIT][COEF_W*i +: COEF_W]);
          nv = integ_st[i];
          if (b.status_flags[i] && ev > 0) ev = 0;
          if (b.status_flags[3+i] && ev < 0) ev = 0;
          if (ev < RAD_Q12 && ev > -RAD_Q12) begin
            r2 = RAD_Q12 * RAD_Q12;
            q = (ev * ev * 65536 + r2 / 2) / r2;
            f = 65536 - q;
            if (f < 0) f = 0;
            p = gain_of(REG_INTEG, i) * ev;
            p = round_shift(p * f, 16);
            p = round_shift(p * longint'(b.step_time), 32);
            nv += p;
          end
          if (nv > lim) nv = lim;
          if (nv < -lim) nv = -lim;
          integ_st[i] = nv;
        end
      end
    end
    o.torque_x   = torque_st[0][ACC_W-1:0];
    o.torque_y   = torque_st[1][ACC_W-1:0];
    o.torque_z   = torque_st[2][ACC_W-1:0];
    o.accel_sp_x = accsp_st[0][ACC_W-1:0];
    o.accel_sp_y = accsp_st[1][ACC_W-1:0];
    o.accel_sp_z = accsp_st[2][ACC_W-1:0];
    o.integral_x = integ_st[0][ACC_W-1:0];
    o.integral_y = integ_st[1][ACC_W-1:0];
    o.integral_z = integ_st[2][ACC_W-1:0];
    return o;
  endfunction

  task automatic check_field(string name, logic [ACC_W-1:0] exp_v, logic [ACC_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < REG_COUNT; i++) reg_mirror[i] = '0;
    for (int i = 0; i < 3; i++) begin
      integ_st[i] = 0;
      torque_st[i] = 0;
      accsp_st[i] = 0;
    end
  end

  assign pending_count = torque_queue.size();

  // Sample every port at the rising edge, before any new drive takes effect.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (cfg_we) reg_mirror[cfg_index] <= cfg_wdata;
      if (in_valid && !in_stall) torque_queue.push_back(predict_torque(in_data));
      if (out_valid && !out_stall) begin
        if (torque_queue.size() == 0) begin
          $error("result beat arrived with nothing expected");
          fail_count++;
        end else begin
          want = torque_queue.pop_front();
          check_field("torque_x", want.torque_x, out_data.torque_x);
          check_field("torque_y", want.torque_y, out_data.torque_y);
          check_field("torque_z", want.torque_z, out_data.torque_z);
          check_field("accel_sp_x", want.accel_sp_x, out_data.accel_sp_x);
          check_field("accel_sp_y", want.accel_sp_y, out_data.accel_sp_y);
          check_field("accel_sp_z", want.accel_sp_z, out_data.accel_sp_z);
          check_field("integral_x", want.integral_x, out_data.integral_x);
          check_field("integral_y", want.integral_y, out_data.integral_y);
          check_field("integral_z", want.integral_z, out_data.integral_z);
        end
      end
    end
  end

endmodule

// ----- dv/three_axis_rate_pid_torque_unit_tb.sv -----
`timescale 1ns / 1ps

module three_axis_rate_pid_torque_unit_tb;
  import tarpt_pkg::*;

  // Ways of filling the register set between phases.
  localparam int SET_TYPICAL = 0;
  localparam int SET_ZERO    = 1;
  localparam int SET_ONES    = 2;
  localparam int SET_MAXPOS  = 3;
  localparam int SET_MINNEG  = 4;
  localparam int SET_WILD    = 5;

  localparam int BLOCK_ITEMS = 175;
  localparam int DRAIN_CYCLES = 150;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending_count;
  int               send_idle = 0;
  int               stall_pct = 0;
  int               sent_beats = 0;
  int               wait_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  three_axis_rate_pid_torque_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  three_axis_rate_pid_torque_unit_chk i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // The result side stalls at random at the current rate.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  function automatic logic [REG_W-1:0] rand_field48(int mode, int idx);
    logic [REG_W-1:0] v;
    for (int i = 0; i < 3; i++) begin
      case (mode)
        SET_ZERO:   v[16*i +: 16] = 16'h0000;
        SET_ONES:   v[16*i +: 16] = 16'hFFFF;
        SET_MAXPOS: v[16*i +: 16] = 16'h7FFF;
        SET_MINNEG: v[16*i +: 16] = 16'h8000;
        SET_WILD:   v[16*i +: 16] = 16'($urandom_range(16'hFFFF));
        default: begin
          if (idx == REG_LIMIT) v[16*i +: 16] = 16'($urandom_range(16'hFFFF));
          else v[16*i +: 16] = 16'($urandom_range(16'h3FFF) - 16'h2000);
        end
      endcase
    end
    return v;
  endfunction

  // Writes all eight registers on consecutive edges; the block is idle here.
  task automatic load_registers(int mode);
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[IDX_W-1:0];
      cfg_wdata <= rand_field48(mode, i);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(in_item_t b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle && gap < 60) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_beats++;
  endtask

  // Lets every expected result drain, then a margin for the block to settle.
  task automatic drain_all();
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_axes(logic cmd, int rate, int tgt, int acc, int dt, int flags);
    in_item_t b;
    b.cmd = cmd;
    b.rate_x = SAMPLE_W'(rate);  b.rate_y = SAMPLE_W'(-rate);  b.rate_z = SAMPLE_W'(rate);
    b.target_x = SAMPLE_W'(tgt); b.target_y = SAMPLE_W'(-tgt); b.target_z = SAMPLE_W'(tgt);
    b.accel_x = SAMPLE_W'(acc);  b.accel_y = SAMPLE_W'(acc);   b.accel_z = SAMPLE_W'(-acc);
    b.step_time = DT_W'(dt);
    b.status_flags = FLAG_W'(flags);
    send_beat(b);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_rate();
    if ($urandom_range(9) < 7) return SAMPLE_W'($urandom_range(65535) - 32768);
    return SAMPLE_W'($urandom_range(24'hFFFFFF));
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t b;
    b.cmd = ($urandom_range(99) < 5) ? CMD_CLEAR : CMD_RUN;
    b.rate_x = rand_rate();
    b.rate_y = rand_rate();
    b.rate_z = rand_rate();
    // Errors mostly inside the weighting window so that the integrator moves.
    if ($urandom_range(9) < 8) begin
      b.target_x = SAMPLE_W'(b.rate_x + $urandom_range(70000) - 35000);
      b.target_y = SAMPLE_W'(b.rate_y + $urandom_range(70000) - 35000);
      b.target_z = SAMPLE_W'(b.rate_z + $urandom_range(70000) - 35000);
    end else begin
      b.target_x = SAMPLE_W'($urandom_range(24'hFFFFFF));
      b.target_y = SAMPLE_W'($urandom_range(24'hFFFFFF));
      b.target_z = SAMPLE_W'($urandom_range(24'hFFFFFF));
    end
    b.accel_x = rand_rate();
    b.accel_y = rand_rate();
    b.accel_z = rand_rate();
    b.step_time = DT_W'($urandom_range(16'hFFFF));
    b.status_flags = FLAG_W'($urandom_range(7'h3F));
    if ($urandom_range(3) == 0) b.status_flags[FLAG_LANDED] = 1'b1;
    return b;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_registers(SET_TYPICAL);

    // Directed beats: extremes, flags, the weighting boundary and the clear.
    send_axes(CMD_CLEAR, 0, 0, 0, 0, 0);
    send_axes(CMD_RUN, 0, 0, 0, 0, 0);
    send_axes(CMD_RUN, 1000, 5000, 200, 16'hFFFF, 0);
    send_axes(CMD_RUN, 8388607, -8388608, 8388607, 16'hFFFF, 0);
    send_axes(CMD_RUN, -8388608, 8388607, -8388608, 16'hFFFF, 0);
    send_axes(CMD_RUN, 0, 28595, 0, 16'hFFFF, 0);
    send_axes(CMD_RUN, 0, -28595, 0, 16'hFFFF, 0);
    send_axes(CMD_RUN, 0, 28594, 0, 16'hFFFF, 0);
    send_axes(CMD_RUN, 0, -28594, 0, 16'hFFFF, 0);
    send_axes(CMD_RUN, 0, 20000, 0, 16'hFFFF, 7'h3F);
    send_axes(CMD_RUN, 0, 20000, 0, 16'hFFFF, 7'h07);
    send_axes(CMD_RUN, 0, -20000, 0, 16'hFFFF, 7'h38);
    send_axes(CMD_RUN, 0, 20000, 0, 16'hFFFF, 7'h40);
    send_axes(CMD_RUN, 500, 12000, -3000, 1, 0);
    send_axes(CMD_RUN, 500, 12000, -3000, 0, 0);
    send_axes(CMD_CLEAR, 8388607, 8388607, 8388607, 16'hFFFF, 7'h7F);
    send_axes(CMD_RUN, 100, 200, 300, 16'h8000, 0);
    drain_all();

    // Random phases, each under a fresh register set and idling pattern.
    for (int blk = 0; blk < 8; blk++) begin
      case (blk)
        1: load_registers(SET_ZERO);
        2: load_registers(SET_ONES);
        3: load_registers(SET_MAXPOS);
        4: load_registers(SET_MINNEG);
        6: load_registers(SET_WILD);
        default: load_registers(SET_TYPICAL);
      endcase
      case (blk % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 87; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 87; end
        default: begin send_idle = 38; stall_pct = 38; end
      endcase
      for (int n = 0; n < BLOCK_ITEMS; n++) send_beat(rand_beat());
      drain_all();
    end

    $display("Ran %0d update and clear beats over nine register sets,", sent_beats);
    $display("with free-running, sender-idle, receiver-stall and mixed phases.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("three_axis_rate_pid_torque_unit_tb: clean");
    end else begin
      $display("three_axis_rate_pid_torque_unit_tb: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("three_axis_rate_pid_torque_unit_tb: errors");
    $finish;
  end

endmodule
